// ===== hw/rtl/lens_point_undistort_defines.svh =====
// Assertion macros shared by the lens undistortion checker.
`ifndef LENS_POINT_UNDISTORT_DEFINES_SVH
`define LENS_POINT_UNDISTORT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define LPU_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, checked outside reset.
`define LPU_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ===== hw/rtl/lpu_pkg.sv =====
// Shared types, constants and fixed-point helpers of the lens point undistortion block.
package lpu_pkg;

   localparam int ITERATIONS_DEF = 5;
   localparam logic signed [23:0] RADIAL_K3_DEF = 24'sd0;

   localparam int PIX_W = 16;
   localparam int COEF_W = 24;
   localparam int OUT_W = 18;
   localparam int FRAC = 28;
   localparam int CFRAC = 20;
   localparam int CSR_IDX_W = 3;

   // Normalizing divider: 16 magnitude bits followed by 28 fraction bits.
   localparam int NORM_BITS = 44;
   localparam int NORM_RADIX = 4;
   localparam int NORM_STEPS = NORM_BITS / NORM_RADIX;

   // Pipeline depth of one correction iteration.
   localparam int ITER_STAGES = 12;

   localparam logic signed [47:0] Q_ONE = 48'sd268435456;
   localparam logic signed [47:0] SAT_MAX = 48'sd2147483647;
   localparam logic signed [47:0] SAT_MIN = -48'sd2147483648;
   localparam logic signed [23:0] OUT_MAX = 24'sd131071;
   localparam logic signed [23:0] OUT_MIN = -24'sd131072;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FOCAL_X = 3'd0,
      CSR_FOCAL_Y = 3'd1,
      CSR_CENTER_X = 3'd2,
      CSR_CENTER_Y = 3'd3,
      CSR_RADIAL_K1 = 3'd4,
      CSR_RADIAL_K2 = 3'd5,
      CSR_TANGENTIAL_P1 = 3'd6,
      CSR_TANGENTIAL_P2 = 3'd7
   } csr_idx_type;

   typedef struct packed {
      logic [PIX_W-1:0] focal_x;
      logic [PIX_W-1:0] focal_y;
      logic [PIX_W-1:0] center_x;
      logic [PIX_W-1:0] center_y;
      logic signed [COEF_W-1:0] k1;
      logic signed [COEF_W-1:0] k2;
      logic signed [COEF_W-1:0] p1;
      logic signed [COEF_W-1:0] p2;
   } lpu_cfg_type;

   // One item as it travels down the pipeline.
   typedef struct packed {
      logic valid;
      logic byp;
      logic [PIX_W-1:0] px;
      logic [PIX_W-1:0] py;
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic signed [31:0] xu;
      logic signed [31:0] yu;
   } lpu_item_type;

   function automatic logic signed [31:0] sat32(input logic signed [47:0] v);
      if (v > SAT_MAX) return 32'sh7fffffff;
      if (v < SAT_MIN) return -32'sh80000000;
      return v[31:0];
   endfunction

   // Q4.28 product back to Q4.28: round half up, then saturate.
   function automatic logic signed [31:0] mulq_fin(input logic signed [63:0] p);
      logic signed [63:0] t;
      t = (p + 64'sd134217728) >>> FRAC;
      return sat32($signed(t[47:0]));
   endfunction

   // Q4.20 coefficient product back to Q4.28 scale, round half up.
   function automatic logic signed [37:0] mulc_fin(input logic signed [57:0] p);
      logic signed [57:0] t;
      t = (p + 58'sd524288) >>> CFRAC;
      return $signed(t[37:0]);
   endfunction

endpackage

// ===== hw/rtl/lpu_norm.sv =====
// Normalization pipeline: (pixel - center) / focal in Q4.28 by a radix-16 divider.
module lpu_norm (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  lpu_pkg::lpu_cfg_type cfg,
   input  lpu_pkg::lpu_item_type item_in,
   output lpu_pkg::lpu_item_type item_out
);
   import lpu_pkg::*;

   typedef struct packed {
      logic [16:0] rem;
      logic [NORM_BITS-1:0] dvd;
      logic [NORM_BITS-1:0] quo;
      logic neg;
   } lpu_div_type;

   lpu_div_type lane_ff [2][NORM_STEPS+1];
   lpu_div_type lane_in [2][NORM_STEPS+1];
   lpu_item_type tag_ff [NORM_STEPS+2];
   lpu_item_type tag_in;
   logic signed [31:0] res_in [2];
   logic [PIX_W-1:0] foc [2];
   logic [PIX_W-1:0] pix [2];
   logic [PIX_W-1:0] ctr [2];

   // A zero focal length is taken as one LSB.
   always_comb begin
      foc[0] = (cfg.focal_x == '0) ? PIX_W'(1) : cfg.focal_x;
      foc[1] = (cfg.focal_y == '0) ? PIX_W'(1) : cfg.focal_y;
      pix[0] = item_in.px;
      pix[1] = item_in.py;
      ctr[0] = cfg.center_x;
      ctr[1] = cfg.center_y;
   end

   // Sign and magnitude of the offset, then four quotient bits per stage.
   always_comb begin
      lpu_div_type tmp;
      logic signed [16:0] d;
      logic [16:0] mag;
      logic [NORM_BITS-1:0] q;
      for (int a = 0; a < 2; a++) begin
         d = $signed({1'b0, pix[a]}) - $signed({1'b0, ctr[a]});
         mag = d[16] ? 17'(-d) : 17'(d);
         lane_in[a][0].rem = '0;
         lane_in[a][0].dvd = {mag[15:0], {FRAC{1'b0}}};
         lane_in[a][0].quo = '0;
         lane_in[a][0].neg = d[16];
         for (int s = 1; s <= NORM_STEPS; s++) begin
            tmp = lane_ff[a][s-1];
            for (int b = 0; b < NORM_RADIX; b++) begin
               tmp.rem = {tmp.rem[15:0], tmp.dvd[NORM_BITS-1]};
               tmp.dvd = {tmp.dvd[NORM_BITS-2:0], 1'b0};
               if (tmp.rem >= {1'b0, foc[a]}) begin
                  tmp.rem = tmp.rem - {1'b0, foc[a]};
                  tmp.quo = {tmp.quo[NORM_BITS-2:0], 1'b1};
               end else begin
                  tmp.quo = {tmp.quo[NORM_BITS-2:0], 1'b0};
               end
            end
            lane_in[a][s] = tmp;
         end
         // Apply the sign and saturate to 32 bits.
         q = lane_ff[a][NORM_STEPS].quo;
         if (!lane_ff[a][NORM_STEPS].neg) begin
            res_in[a] = (q > NORM_BITS'(32'h7fffffff)) ? 32'sh7fffffff : $signed(q[31:0]);
         end else begin
            res_in[a] = (q > NORM_BITS'(33'h080000000)) ? -32'sh80000000 :
                        $signed(32'(-q[31:0]));
         end
      end
   end

   // The last tag stage takes the quotients as the starting estimate.
   always_comb begin
      tag_in = tag_ff[NORM_STEPS];
      tag_in.x0 = res_in[0];
      tag_in.y0 = res_in[1];
      tag_in.xu = res_in[0];
      tag_in.yu = res_in[1];
   end

   // Divider lanes and the item tag move together.
   always_ff @(posedge clock) begin
      if (en) begin
         for (int a = 0; a < 2; a++) begin
            for (int s = 0; s <= NORM_STEPS; s++) begin
               lane_ff[a][s] <= lane_in[a][s];
            end
         end
      end
      if (reset) begin
         for (int s = 0; s <= NORM_STEPS + 1; s++) begin
            tag_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         tag_ff[0] <= item_in;
         for (int s = 1; s <= NORM_STEPS; s++) begin
            tag_ff[s] <= tag_ff[s-1];
         end
         tag_ff[NORM_STEPS+1] <= tag_in;
      end
   end

   assign item_out = tag_ff[NORM_STEPS+1];

endmodule

// ===== hw/rtl/lpu_iter.sv =====
// One correction iteration of the radial and tangential lens model, twelve stages deep.
module lpu_iter #(
   parameter logic signed [23:0] RADIAL_K3 = lpu_pkg::RADIAL_K3_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  lpu_pkg::lpu_cfg_type cfg,
   input  lpu_pkg::lpu_item_type item_in,
   output lpu_pkg::lpu_item_type item_out
);
   import lpu_pkg::*;

   lpu_item_type t_ff [ITER_STAGES];
   lpu_item_type t_last;

   logic signed [63:0] pxx_ff, pyy_ff, pxy_ff;
   logic signed [31:0] xx_ff, yy_ff, xy_ff;
   logic signed [31:0] r2_ff, xx2_ff, yy2_ff, xy2_ff;
   logic signed [63:0] pr4_ff;
   logic signed [57:0] pk1_ff, pt1x_ff, pt2y_ff;
   logic signed [33:0] ap2x_ff, ap1y_ff;
   logic signed [31:0] r2b_ff, r2c_ff;
   logic signed [31:0] r4_ff;
   logic signed [37:0] c1_ff, c1b_ff, c1c_ff, c2_ff;
   logic signed [57:0] pt2x_ff, pt1y_ff, pt1xb_ff, pt2yb_ff;
   logic signed [63:0] pr6_ff;
   logic signed [57:0] pk2_ff, pk3_ff;
   logic signed [31:0] r6_ff;
   logic signed [39:0] c12_ff;
   logic signed [31:0] dx_ff [5:9];
   logic signed [31:0] dy_ff [5:9];
   logic signed [31:0] rad_ff;
   logic signed [63:0] pxr_ff, pyr_ff;
   logic signed [31:0] xd_ff, yd_ff;

   // New estimate for the last tag stage.
   always_comb begin
      t_last = t_ff[ITER_STAGES-2];
      t_last.xu = sat32(48'(t_ff[ITER_STAGES-2].xu) - 48'(xd_ff)
                        + 48'(t_ff[ITER_STAGES-2].x0));
      t_last.yu = sat32(48'(t_ff[ITER_STAGES-2].yu) - 48'(yd_ff)
                        + 48'(t_ff[ITER_STAGES-2].y0));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // Squares and cross product.
         pxx_ff <= item_in.xu * item_in.xu;
         pyy_ff <= item_in.yu * item_in.yu;
         pxy_ff <= item_in.xu * item_in.yu;
         // Round back to Q4.28.
         xx_ff <= mulq_fin(pxx_ff);
         yy_ff <= mulq_fin(pyy_ff);
         xy_ff <= mulq_fin(pxy_ff);
         // Squared radius.
         r2_ff <= sat32(48'(xx_ff) + 48'(yy_ff));
         xx2_ff <= xx_ff;
         yy2_ff <= yy_ff;
         xy2_ff <= xy_ff;
         // r4 product, k1 term and the tangential operands.
         pr4_ff <= r2_ff * r2_ff;
         pk1_ff <= cfg.k1 * r2_ff;
         ap2x_ff <= 34'(r2_ff) + (34'(xx2_ff) <<< 1);
         ap1y_ff <= 34'(r2_ff) + (34'(yy2_ff) <<< 1);
         pt1x_ff <= cfg.p1 * (34'(xy2_ff) <<< 1);
         pt2y_ff <= cfg.p2 * (34'(xy2_ff) <<< 1);
         r2b_ff <= r2_ff;
         // r4, k1 term and remaining tangential products.
         r4_ff <= mulq_fin(pr4_ff);
         c1_ff <= mulc_fin(pk1_ff);
         pt2x_ff <= cfg.p2 * ap2x_ff;
         pt1y_ff <= cfg.p1 * ap1y_ff;
         pt1xb_ff <= pt1x_ff;
         pt2yb_ff <= pt2y_ff;
         r2c_ff <= r2b_ff;
         // r6 product, k2 term and tangential offsets.
         pr6_ff <= r4_ff * r2c_ff;
         pk2_ff <= cfg.k2 * r4_ff;
         dx_ff[5] <= sat32(48'(mulc_fin(pt1xb_ff)) + 48'(mulc_fin(pt2x_ff)));
         dy_ff[5] <= sat32(48'(mulc_fin(pt1y_ff)) + 48'(mulc_fin(pt2yb_ff)));
         c1b_ff <= c1_ff;
         // r6 and k2 term.
         r6_ff <= mulq_fin(pr6_ff);
         c2_ff <= mulc_fin(pk2_ff);
         c1c_ff <= c1b_ff;
         // k3 product and partial radial sum.
         pk3_ff <= RADIAL_K3 * r6_ff;
         c12_ff <= 40'(c1c_ff) + 40'(c2_ff);
         // Radial factor.
         rad_ff <= sat32(Q_ONE + 48'(c12_ff) + 48'(mulc_fin(pk3_ff)));
         // Estimate times radial factor.
         pxr_ff <= t_ff[8].xu * rad_ff;
         pyr_ff <= t_ff[8].yu * rad_ff;
         // Distorted estimate.
         xd_ff <= sat32(48'(mulq_fin(pxr_ff)) + 48'(dx_ff[9]));
         yd_ff <= sat32(48'(mulq_fin(pyr_ff)) + 48'(dy_ff[9]));
         for (int s = 6; s <= 9; s++) begin
            dx_ff[s] <= dx_ff[s-1];
            dy_ff[s] <= dy_ff[s-1];
         end
      end
      // Item tag, with the new estimate written in the last stage.
      if (reset) begin
         for (int s = 0; s < ITER_STAGES; s++) begin
            t_ff[s].valid <= 1'b0;
         end
      end else if (en) begin
         t_ff[0] <= item_in;
         for (int s = 1; s < ITER_STAGES - 1; s++) begin
            t_ff[s] <= t_ff[s-1];
         end
         t_ff[ITER_STAGES-1] <= t_last;
      end
   end

   assign item_out = t_ff[ITER_STAGES-1];

endmodule

// ===== hw/rtl/lpu_out.sv =====
// Back-projection to pixels with 18-bit saturation, and the result register.
module lpu_out (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  lpu_pkg::lpu_cfg_type        cfg,
   input  lpu_pkg::lpu_item_type       item_in,
   output logic                        out_valid,
   output logic signed [lpu_pkg::OUT_W-1:0] out_x,
   output logic signed [lpu_pkg::OUT_W-1:0] out_y,
   output logic                        out_clip,
   output logic                        out_byp
);
   import lpu_pkg::*;

   lpu_item_type tag_ff;
   logic signed [48:0] pvx_ff, pvy_ff;
   logic signed [48:0] rx_t, ry_t;
   logic signed [23:0] rx_in, ry_in;
   logic [PIX_W-1:0] fx, fy;
   logic valid_ff, clip_ff, byp_ff;
   logic signed [OUT_W-1:0] x_ff, y_ff;
   logic signed [OUT_W-1:0] x_in, y_in;
   logic clip_in;

   assign fx = (cfg.focal_x == '0) ? PIX_W'(1) : cfg.focal_x;
   assign fy = (cfg.focal_y == '0) ? PIX_W'(1) : cfg.focal_y;

   // Round the scaled value, add the center and saturate.
   always_comb begin
      rx_t = (pvx_ff + 49'sd134217728) >>> FRAC;
      ry_t = (pvy_ff + 49'sd134217728) >>> FRAC;
      rx_in = $signed(rx_t[23:0]) + $signed({8'd0, cfg.center_x});
      ry_in = $signed(ry_t[23:0]) + $signed({8'd0, cfg.center_y});
      clip_in = 1'b0;
      if (rx_in > OUT_MAX) begin
         x_in = OUT_MAX[OUT_W-1:0];
         clip_in = 1'b1;
      end else if (rx_in < OUT_MIN) begin
         x_in = OUT_MIN[OUT_W-1:0];
         clip_in = 1'b1;
      end else begin
         x_in = rx_in[OUT_W-1:0];
      end
      if (ry_in > OUT_MAX) begin
         y_in = OUT_MAX[OUT_W-1:0];
         clip_in = 1'b1;
      end else if (ry_in < OUT_MIN) begin
         y_in = OUT_MIN[OUT_W-1:0];
         clip_in = 1'b1;
      end else begin
         y_in = ry_in[OUT_W-1:0];
      end
      if (tag_ff.byp) begin
         x_in = $signed({2'b00, tag_ff.px});
         y_in = $signed({2'b00, tag_ff.py});
         clip_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pvx_ff <= item_in.xu * $signed({1'b0, fx});
         pvy_ff <= item_in.yu * $signed({1'b0, fy});
         x_ff <= x_in;
         y_ff <= y_in;
         clip_ff <= clip_in;
         byp_ff <= tag_ff.byp;
      end
      if (reset) begin
         tag_ff.valid <= 1'b0;
         valid_ff <= 1'b0;
      end else if (en) begin
         tag_ff <= item_in;
         valid_ff <= tag_ff.valid;
      end
   end

   assign out_valid = valid_ff;
   assign out_x = x_ff;
   assign out_y = y_ff;
   assign out_clip = clip_ff;
   assign out_byp = byp_ff;

endmodule

// ===== hw/rtl/lens_point_undistort.sv =====
// Top level of the iterative lens point undistortion pipeline.
// One item enters per clock and the pipeline is fully stalled only while a result waits
// at rsp with rsp_ready low. Items pass through the radix-16 normalizing divider, then
// through ITERATIONS correction iterations (five by default; each is the multiply, round
// and saturate chain of the lens model), then the pixel mapping and the result register.
// Configuration registers may be written only while no item is in flight; csr_ready is
// always high.
module lens_point_undistort #(
   parameter int ITERATIONS = lpu_pkg::ITERATIONS_DEF,
   parameter logic signed [23:0] RADIAL_K3 = lpu_pkg::RADIAL_K3_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [lpu_pkg::PIX_W-1:0] req_pixel_x,
   input  logic [lpu_pkg::PIX_W-1:0] req_pixel_y,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [lpu_pkg::OUT_W-1:0] rsp_corrected_x,
   output logic signed [lpu_pkg::OUT_W-1:0] rsp_corrected_y,
   output logic rsp_clipped,
   output logic rsp_bypassed,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [lpu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [lpu_pkg::COEF_W-1:0] csr_data
);
   import lpu_pkg::*;

   lpu_cfg_type cfg_ff;
   lpu_item_type item_in;
   lpu_item_type chain [ITERATIONS+1];
   logic en;

   // The whole pipeline advances unless a result is held at the output.
   assign en = !rsp_valid || rsp_ready;
   assign req_ready = en;
   assign csr_ready = 1'b1;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x <= 16'd8000;
         cfg_ff.focal_y <= 16'd8000;
         cfg_ff.center_x <= 16'd5120;
         cfg_ff.center_y <= 16'd3840;
         cfg_ff.k1 <= '0;
         cfg_ff.k2 <= '0;
         cfg_ff.p1 <= '0;
         cfg_ff.p2 <= '0;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_FOCAL_X: cfg_ff.focal_x <= csr_data[PIX_W-1:0];
            CSR_FOCAL_Y: cfg_ff.focal_y <= csr_data[PIX_W-1:0];
            CSR_CENTER_X: cfg_ff.center_x <= csr_data[PIX_W-1:0];
            CSR_CENTER_Y: cfg_ff.center_y <= csr_data[PIX_W-1:0];
            CSR_RADIAL_K1: cfg_ff.k1 <= $signed(csr_data);
            CSR_RADIAL_K2: cfg_ff.k2 <= $signed(csr_data);
            CSR_TANGENTIAL_P1: cfg_ff.p1 <= $signed(csr_data);
            CSR_TANGENTIAL_P2: cfg_ff.p2 <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // Incoming item; the pass-through decision is taken here.
   always_comb begin
      item_in = '0;
      item_in.valid = req_valid;
      item_in.px = req_pixel_x;
      item_in.py = req_pixel_y;
      item_in.byp = (cfg_ff.k1 >= -24'sd1) && (cfg_ff.k1 <= 24'sd1) &&
                    (cfg_ff.k2 >= -24'sd1) && (cfg_ff.k2 <= 24'sd1);
   end

   lpu_norm u_norm (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .item_in(item_in), .item_out(chain[0])
   );

   for (genvar g = 0; g < ITERATIONS; g++) begin : g_iter
      lpu_iter #(.RADIAL_K3(RADIAL_K3)) u_iter (
         .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
         .item_in(chain[g]), .item_out(chain[g+1])
      );
   end

   lpu_out u_out (
      .clock(clock), .reset(reset), .en(en), .cfg(cfg_ff),
      .item_in(chain[ITERATIONS]),
      .out_valid(rsp_valid), .out_x(rsp_corrected_x), .out_y(rsp_corrected_y),
      .out_clip(rsp_clipped), .out_byp(rsp_bypassed)
   );

endmodule

// ===== hw/rtl/lpu_checker.sv =====
// Port-level checker for the lens point undistortion block, bound to the top level.
`include "lens_point_undistort_defines.svh"

module lpu_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic signed [17:0] rsp_corrected_x,
   input logic signed [17:0] rsp_corrected_y,
   input logic rsp_clipped,
   input logic rsp_bypassed
);
   // A passed-through item is never reported as saturated.
   `LPU_ASSERT_IMP(a_byp_no_clip, clock, reset, rsp_valid && rsp_bypassed, !rsp_clipped)
   // A passed-through item carries the unsigned input coordinates.
   `LPU_ASSERT_IMP(a_byp_range, clock, reset, rsp_valid && rsp_bypassed,
                   rsp_corrected_x[17:16] == 2'b00 && rsp_corrected_y[17:16] == 2'b00)
   // The input side stalls exactly when a result is held.
   `LPU_ASSERT_IMP(a_stall, clock, reset, 1'b1, req_ready == (!rsp_valid || rsp_ready))
   // A held result keeps its value.
   `LPU_ASSERT_NXT(a_hold, clock, reset, rsp_valid && !rsp_ready,
                   rsp_valid && $stable(rsp_corrected_x) && $stable(rsp_corrected_y))
endmodule

bind lens_point_undistort lpu_checker u_lpu_checker (
   .clock(clock), .reset(reset),
   .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_corrected_x(rsp_corrected_x), .rsp_corrected_y(rsp_corrected_y),
   .rsp_clipped(rsp_clipped), .rsp_bypassed(rsp_bypassed)
);

// ===== tb/lens_point_undistort_checker.sv =====
// Checker for the lens point undistortion block: predicts each corrected point and compares.
`timescale 1ns / 100ps

module lens_point_undistort_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   input  logic req_ready,
   input  logic [15:0] req_pixel_x,
   input  logic [15:0] req_pixel_y,
   input  logic rsp_valid,
   input  logic rsp_ready,
   input  logic signed [17:0] rsp_corrected_x,
   input  logic signed [17:0] rsp_corrected_y,
   input  logic rsp_clipped,
   input  logic rsp_bypassed,
   input  logic csr_valid,
   input  logic csr_ready,
   input  logic [2:0] csr_index,
   input  logic [23:0] csr_data,
   output int fail_count,
   output int points_in_flight
);
   import lpu_pkg::*;

   localparam int STEPS = ITERATIONS_DEF;
   localparam longint LENS_K3 = longint'(RADIAL_K3_DEF);

   typedef struct {
      logic signed [17:0] cx;
      logic signed [17:0] cy;
      logic clip;
      logic byp;
   } point_type;

   point_type corrected_q[$];

   // Local copy of the lens registers.
   logic [15:0] fx, fy, ctr_x, ctr_y;
   logic signed [23:0] k1, k2, p1, p2;

   function automatic longint round_shift(longint p, int s);
      return (p + (longint'(1) << (s - 1))) >>> s;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clamp32(round_shift(a * b, 28));
   endfunction

   function automatic longint cmul(longint k, longint v);
      return round_shift(k * v, 20);
   endfunction

   function automatic longint to_norm(logic [15:0] pix, logic [15:0] ctr, logic [15:0] foc);
      longint d;
      longint f;
      d = longint'(pix) - longint'(ctr);
      f = (foc == 0) ? 1 : longint'(foc);
      return clamp32((d * (longint'(1) << 28)) / f);
   endfunction

   function automatic logic signed [17:0] to_pix(longint v, logic [15:0] ctr,
                                                 logic [15:0] foc, ref logic clip);
      longint f;
      longint r;
      f = (foc == 0) ? 1 : longint'(foc);
      r = round_shift(v * f, 28) + longint'(ctr);
      if (r > 131071) begin
         clip = 1'b1;
         return 18'sd131071;
      end
      if (r < -131072) begin
         clip = 1'b1;
         return -18'sd131072;
      end
      return r[17:0];
   endfunction

   // Iterative undistortion of one point under the current registers.
   function automatic point_type undistort(logic [15:0] px, logic [15:0] py);
      point_type pt;
      longint a1, a2, b1, b2, x0, y0, xu, yu;
      longint xx, yy, xy, r2, r4, r6, rad, dx, dy, xd, yd;
      logic clip;
      a1 = longint'(k1);
      a2 = longint'(k2);
      b1 = longint'(p1);
      b2 = longint'(p2);
      clip = 1'b0;
      // Negligible radial terms pass the point through.
      if (a1 >= -1 && a1 <= 1 && a2 >= -1 && a2 <= 1) begin
         pt.cx = {2'b00, px};
         pt.cy = {2'b00, py};
         pt.clip = 1'b0;
         pt.byp = 1'b1;
         return pt;
      end
      x0 = to_norm(px, ctr_x, fx);
      y0 = to_norm(py, ctr_y, fy);
      xu = x0;
      yu = y0;
      for (int i = 0; i < STEPS; i++) begin
         xx = qmul(xu, xu);
         yy = qmul(yu, yu);
         xy = qmul(xu, yu);
         r2 = clamp32(xx + yy);
         r4 = qmul(r2, r2);
         r6 = qmul(r4, r2);
         rad = clamp32((longint'(1) << 28) + cmul(a1, r2) + cmul(a2, r4) + cmul(LENS_K3, r6));
         dx = clamp32(cmul(b1, 2 * xy) + cmul(b2, r2 + 2 * xx));
         dy = clamp32(cmul(b1, r2 + 2 * yy) + cmul(b2, 2 * xy));
         xd = clamp32(qmul(xu, rad) + dx);
         yd = clamp32(qmul(yu, rad) + dy);
         xu = clamp32(xu - xd + x0);
         yu = clamp32(yu - yd + y0);
      end
      pt.cx = to_pix(xu, ctr_x, fx, clip);
      pt.cy = to_pix(yu, ctr_y, fy, clip);
      pt.clip = clip;
      pt.byp = 1'b0;
      return pt;
   endfunction

   task automatic report_mismatch(string what, longint got, longint want);
      $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   assign points_in_flight = corrected_q.size();

   // Register writes, accepted items and results, all sampled at the rising edge.
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         fx <= 16'd8000;
         fy <= 16'd8000;
         ctr_x <= 16'd5120;
         ctr_y <= 16'd3840;
         k1 <= '0;
         k2 <= '0;
         p1 <= '0;
         p2 <= '0;
         corrected_q.delete();
      end else begin
         if (req_valid && req_ready)
            corrected_q.insert(corrected_q.size(), undistort(req_pixel_x, req_pixel_y));
         if (rsp_valid && rsp_ready) begin
            if (corrected_q.size() == 0) begin
               report_mismatch("items outstanding", 0, 1);
            end else begin
               want = corrected_q.pop_front();
               if (rsp_corrected_x !== want.cx)
                  report_mismatch("corrected_x", rsp_corrected_x, want.cx);
               if (rsp_corrected_y !== want.cy)
                  report_mismatch("corrected_y", rsp_corrected_y, want.cy);
               if (rsp_clipped !== want.clip)
                  report_mismatch("clipped", rsp_clipped, want.clip);
               if (rsp_bypassed !== want.byp)
                  report_mismatch("bypassed", rsp_bypassed, want.byp);
            end
         end
         if (csr_valid && csr_ready) begin
            case (csr_idx_type'(csr_index))
               CSR_FOCAL_X: fx <= csr_data[15:0];
               CSR_FOCAL_Y: fy <= csr_data[15:0];
               CSR_CENTER_X: ctr_x <= csr_data[15:0];
               CSR_CENTER_Y: ctr_y <= csr_data[15:0];
               CSR_RADIAL_K1: k1 <= csr_data;
               CSR_RADIAL_K2: k2 <= csr_data;
               CSR_TANGENTIAL_P1: p1 <= csr_data;
               CSR_TANGENTIAL_P2: p2 <= csr_data;
               default: ;
            endcase
         end
      end
   end

   initial fail_count = 0;

endmodule

// ===== tb/lens_point_undistort_tb.sv =====
// Testbench top for the lens point undistortion block: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module lens_point_undistort_tb;
   import lpu_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 120;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [15:0] req_pixel_x = '0;
   logic [15:0] req_pixel_y = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [17:0] rsp_corrected_x;
   logic signed [17:0] rsp_corrected_y;
   logic rsp_clipped;
   logic rsp_bypassed;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [23:0] csr_data = '0;
   int fail_count;
   int points_in_flight;
   int cycle_count = 0;
   int hold_requests = 0;

   always #6 clock = ~clock;

   lens_point_undistort u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_corrected_x(rsp_corrected_x), .rsp_corrected_y(rsp_corrected_y),
      .rsp_clipped(rsp_clipped), .rsp_bypassed(rsp_bypassed),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   lens_point_undistort_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_pixel_x(req_pixel_x), .req_pixel_y(req_pixel_y),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_corrected_x(rsp_corrected_x), .rsp_corrected_y(rsp_corrected_y),
      .rsp_clipped(rsp_clipped), .rsp_bypassed(rsp_bypassed),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .points_in_flight(points_in_flight)
   );

   // Run watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lens_point_undistort regression: fail");
         $finish;
      end
   end

   // Result side: stall modes that change now and then, plus a long hold-off on request.
   initial begin
      int mode;
      int span;
      int holds_done;
      holds_done = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(10, 150);
         repeat (span) begin
            @(negedge clock);
            if (hold_requests != holds_done) begin
               holds_done = hold_requests;
               rsp_ready = 1'b0;
               repeat (300) @(negedge clock);
            end
            case (mode)
               0: rsp_ready = 1'b1;
               1: rsp_ready = ($urandom_range(0, 1) == 1);
               2: rsp_ready = ($urandom_range(0, 3) == 0);
               default: rsp_ready = ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // Called at a falling edge; returns at a falling edge with the register write done.
   task automatic write_reg(csr_idx_type idx, logic [23:0] value);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic load_lens(logic [15:0] fx, logic [15:0] fy, logic [15:0] cx,
                            logic [15:0] cy, logic [23:0] k1, logic [23:0] k2,
                            logic [23:0] p1, logic [23:0] p2);
      // Upper bits of the 16-bit registers carry junk that must be ignored.
      write_reg(CSR_FOCAL_X, {8'($urandom_range(0, 255)), fx});
      write_reg(CSR_FOCAL_Y, {8'($urandom_range(0, 255)), fy});
      write_reg(CSR_CENTER_X, {8'($urandom_range(0, 255)), cx});
      write_reg(CSR_CENTER_Y, {8'($urandom_range(0, 255)), cy});
      write_reg(CSR_RADIAL_K1, k1);
      write_reg(CSR_RADIAL_K2, k2);
      write_reg(CSR_TANGENTIAL_P1, p1);
      write_reg(CSR_TANGENTIAL_P2, p2);
   endtask

   // Offers one item and holds it until accepted; valid stays high on return.
   task automatic send_point(logic [15:0] x, logic [15:0] y);
      req_valid = 1'b1;
      req_pixel_x = x;
      req_pixel_y = y;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic send_burst(int count);
      int burst_left;
      burst_left = $urandom_range(1, 30);
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            send_point(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         else
            send_point(16'($urandom_range(0, 12000)), 16'($urandom_range(0, 9000)));
         burst_left--;
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 30);
            req_valid = 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
      req_valid = 1'b0;
   endtask

   // Waits for every outstanding result, then lets the pipeline settle.
   task automatic drain;
      while (points_in_flight != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic send_corners;
      send_point(16'd0, 16'd0);
      send_point(16'hffff, 16'hffff);
      send_point(16'd0, 16'hffff);
      send_point(16'hffff, 16'd0);
      send_point(16'd5120, 16'd3840);
      send_point(16'h5555, 16'haaaa);
      send_point(16'haaaa, 16'h5555);
      req_valid = 1'b0;
   endtask

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // Reset registers: zero coefficients, so every point passes through.
      send_corners();
      drain();

      // A typical barrel lens.
      load_lens(16'd8000, 16'd8000, 16'd5120, 16'd3840,
                -24'sd209715, 24'sd52429, 24'sd1000, -24'sd1000);
      send_corners();
      send_point(16'd5121, 16'd3839);
      send_point(16'd10240, 16'd7680);
      req_valid = 1'b0;
      drain();

      // Extreme coefficients and the smallest focal length push everything to saturation.
      load_lens(16'd16, 16'd0, 16'd0, 16'hffff,
                24'h7fffff, 24'h800000, 24'h800000, 24'h7fffff);
      send_corners();
      drain();

      // Coefficients just at the pass-through boundary.
      load_lens(16'hffff, 16'hffff, 16'hffff, 16'd0, 24'd1, 24'hffffff, 24'h123456, 24'h654321);
      send_corners();
      drain();

      // Just outside the pass-through boundary, with the result side held off.
      load_lens(16'd8000, 16'd7000, 16'd5000, 16'd4000, 24'd2, 24'hfffffe, 24'd0, 24'd0);
      hold_requests++;
      send_burst(120);
      drain();

      // Random lenses, mostly realistic, sometimes anything the registers hold.
      for (int ph = 0; ph < 10; ph++) begin
         if (ph % 3 == 2)
            load_lens(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
         else
            load_lens(16'($urandom_range(3000, 20000)), 16'($urandom_range(3000, 20000)),
                      16'($urandom_range(2000, 10000)), 16'($urandom_range(2000, 8000)),
                      24'($signed($urandom_range(0, 600000)) - 300000),
                      24'($signed($urandom_range(0, 200000)) - 100000),
                      24'($signed($urandom_range(0, 20000)) - 10000),
                      24'($signed($urandom_range(0, 20000)) - 10000));
         send_burst(64);
         drain();
      end

      if (fail_count == 0)
         $display("lens_point_undistort regression: pass");
      else
         $display("lens_point_undistort regression: fail");
      $finish;
   end

endmodule

// ===== lens_point_undistort.f =====
+incdir+hw/rtl
hw/rtl/lpu_pkg.sv
hw/rtl/lpu_norm.sv
hw/rtl/lpu_iter.sv
hw/rtl/lpu_out.sv
hw/rtl/lens_point_undistort.sv
hw/rtl/lpu_checker.sv
tb/lens_point_undistort_checker.sv
tb/lens_point_undistort_tb.sv
